// ----- design/imf_pkg.sv -----
// ----------------------------------------------------------------------------
// imf_pkg
// Shared types and constants of the message fragmenter: header sizes, the
// register map, the configuration bundle and the per-request run record.
// ----------------------------------------------------------------------------
package imf_pkg;

  // Header sizes and the smallest usable fragment size
  localparam logic [15:0] FirstHdrLen = 16'd10;
  localparam logic [15:0] NextHdrLen  = 16'd6;
  localparam logic [15:0] MinFrag     = 16'd18;

  // Most result bytes caused by one request: a first header plus the payload byte
  localparam int unsigned RunBytes = 11;
  localparam int unsigned RunCntW  = $clog2(RunBytes + 1);

  localparam logic [RunCntW-1:0] RunFirstLen = RunCntW'(11);
  localparam logic [RunCntW-1:0] RunNextLen  = RunCntW'(7);
  localparam logic [RunCntW-1:0] RunDataLen  = RunCntW'(1);

  // Configuration register map
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegMaxFragSize = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOpcode      = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFirstExtOp  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegNextExtOp   = 2'd3;

  localparam logic [15:0] MaxFragReset    = 16'd6144;
  localparam logic [7:0]  OpcodeReset     = 8'd3;
  localparam logic [7:0]  FirstExtOpReset = 8'd12;
  localparam logic [7:0]  NextExtOpReset  = 8'd8;

  typedef struct packed {
    logic [15:0] max_frag;
    logic [7:0]  opcode;
    logic [7:0]  first_ext;
    logic [7:0]  next_ext;
  } cfg_t;

  // Bytes of one request in send order, lowest entry first
  typedef struct packed {
    logic [RunBytes-1:0][7:0] data;
    logic [RunCntW-1:0]       count;
    logic                     eof;
    logic                     eom;
  } run_t;

endpackage

// ----- design/ipc_message_fragmenter_unit.sv -----
// ----------------------------------------------------------------------------
// ipc_message_fragmenter_unit
// Splits messages into framed fragments with inserted headers.
// ----------------------------------------------------------------------------
// Each accepted request carries one payload byte; the opening request of a
// message also carries its length and stream id. When no header falls due
// and the sink is ready, payload streams at one byte per cycle. A request
// that opens a fragment first sends its header: ten bytes for the first
// fragment, six for each later one. The output byte shifter sends one byte
// per cycle while the sink is ready. An opening request with length zero is
// dropped without results. Configuration is written through a plain write
// port; the user must write it only while no message is in flight, as the
// block itself does not enforce this.
module ipc_message_fragmenter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] payload_byte, [39:8] message_length, [71:40] stream_ident
  input  logic [71:0] s_axis_tdata,
  // Frame byte stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] frame_byte
  output logic [7:0]  m_axis_tdata,
  // last_of_run
  output logic        m_axis_tlast,
  // [0] end_of_frame, [1] end_of_message
  output logic [1:0]  m_axis_tuser
);
  import imf_pkg::*;

  cfg_t cfg_q;
  run_t run;
  logic run_valid, run_ready;
  logic eof, eom;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_frag  <= MaxFragReset;
      cfg_q.opcode    <= OpcodeReset;
      cfg_q.first_ext <= FirstExtOpReset;
      cfg_q.next_ext  <= NextExtOpReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMaxFragSize: cfg_q.max_frag  <= cfg_data_i;
        RegOpcode:      cfg_q.opcode    <= cfg_data_i[7:0];
        RegFirstExtOp:  cfg_q.first_ext <= cfg_data_i[7:0];
        RegNextExtOp:   cfg_q.next_ext  <= cfg_data_i[7:0];
        default:        cfg_q           <= cfg_q;
      endcase
    end
  end

  imf_framer u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata[7:0]),
    .in_len_i    (s_axis_tdata[39:8]),
    .in_stream_i (s_axis_tdata[71:40]),
    .run_ready_i (run_ready),
    .run_valid_o (run_valid),
    .run_o       (run)
  );

  imf_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_valid_i (run_valid),
    .run_ready_o (run_ready),
    .run_i       (run),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_eof_o   (eof),
    .out_eom_o   (eom)
  );

  assign m_axis_tuser = {eom, eof};

endmodule

// ----- design/imf_framer.sv -----
// ----------------------------------------------------------------------------
// imf_framer
// Input register and message state. Decides per request whether a first or a
// later fragment header falls due, builds the header bytes, patches the
// stream id into the payload and hands one run record to the serializer.
// ----------------------------------------------------------------------------
module imf_framer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  imf_pkg::cfg_t    cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic [31:0]      in_len_i,
  input  logic [31:0]      in_stream_i,
  input  logic             run_ready_i,
  output logic             run_valid_o,
  output imf_pkg::run_t    run_o
);
  import imf_pkg::*;

  typedef enum logic [1:0] {
    HDR_NONE,
    HDR_FIRST,
    HDR_NEXT
  } hdr_e;

  // Input register
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic [31:0] in_len_q;
  logic [31:0] in_stream_q;

  // Message state
  logic [15:0] frag_cnt_q, frag_cnt_d;
  logic [31:0] msg_left_q, msg_left_d;
  logic [15:0] frag_left_q, frag_left_d;
  logic [3:0]  pos_q, pos_d;
  logic [31:0] stream_q, stream_d;

  logic        open_msg, drop, consume, push;
  logic [15:0] mx, cap_first, cap_next, flen, frag_eff, cnt_inc;
  logic        fits_first, fits_next;
  logic [31:0] msg_eff, stream_eff;
  logic [3:0]  pos_eff;
  logic [1:0]  sel;
  logic [7:0]  pay;
  hdr_e        hdr;

  // Drop a zero-length opening request, otherwise wait for the serializer
  assign open_msg    = (msg_left_q == 32'd0);
  assign drop        = open_msg && (in_len_q == 32'd0);
  assign consume     = in_valid_q && (drop || run_ready_i);
  assign push        = in_valid_q && !drop && run_ready_i;
  assign in_ready_o  = !in_valid_q || consume;
  assign run_valid_o = push;

  // Fragment capacities
  assign mx         = (cfg_i.max_frag < MinFrag) ? MinFrag : cfg_i.max_frag;
  assign cap_first  = mx - FirstHdrLen;
  assign cap_next   = mx - NextHdrLen;
  assign fits_first = (in_len_q <= {16'd0, cap_first});
  assign fits_next  = (msg_left_q <= {16'd0, cap_next});
  assign cnt_inc    = frag_cnt_q + 16'd1;

  // Pick header and effective state for this request
  always_comb begin
    hdr        = HDR_NONE;
    msg_eff    = msg_left_q;
    frag_eff   = frag_left_q;
    pos_eff    = pos_q;
    stream_eff = stream_q;
    frag_cnt_d = frag_cnt_q;
    flen       = mx;
    if (open_msg) begin
      hdr        = HDR_FIRST;
      msg_eff    = in_len_q;
      pos_eff    = 4'd0;
      stream_eff = in_stream_q;
      frag_cnt_d = (cnt_inc == 16'd0) ? 16'd1 : cnt_inc;
      if (fits_first) begin
        frag_eff = in_len_q[15:0];
        flen     = in_len_q[15:0] + FirstHdrLen;
      end else begin
        frag_eff = cap_first;
      end
    end else if (frag_left_q == 16'd0) begin
      hdr = HDR_NEXT;
      if (fits_next) begin
        frag_eff = msg_left_q[15:0];
        flen     = msg_left_q[15:0] + NextHdrLen;
      end else begin
        frag_eff = cap_next;
      end
    end
  end

  // Overwrite payload bytes 4 to 7 with a nonzero stream id, big-endian
  assign sel = 2'd3 - pos_eff[1:0];
  always_comb begin
    pay   = in_byte_q;
    pos_d = pos_eff;
    if (pos_eff < 4'd8) begin
      if (pos_eff >= 4'd4 && stream_eff != 32'd0) begin
        pay = stream_eff[{sel, 3'b000} +: 8];
      end
      pos_d = pos_eff + 4'd1;
    end
  end

  assign frag_left_d = frag_eff - 16'd1;
  assign msg_left_d  = msg_eff - 32'd1;
  assign stream_d    = stream_eff;

  // Assemble the run record
  always_comb begin
    run_o.data    = '0;
    run_o.count   = RunDataLen;
    run_o.eof     = (frag_left_d == 16'd0);
    run_o.eom     = (msg_left_d == 32'd0);
    run_o.data[0] = flen[15:8];
    run_o.data[1] = flen[7:0];
    run_o.data[2] = cfg_i.opcode;
    unique case (hdr)
      HDR_FIRST: begin
        run_o.count    = RunFirstLen;
        run_o.data[3]  = cfg_i.first_ext;
        run_o.data[4]  = in_len_q[31:24];
        run_o.data[5]  = in_len_q[23:16];
        run_o.data[6]  = in_len_q[15:8];
        run_o.data[7]  = in_len_q[7:0];
        run_o.data[8]  = frag_cnt_d[15:8];
        run_o.data[9]  = frag_cnt_d[7:0];
        run_o.data[10] = pay;
      end
      HDR_NEXT: begin
        run_o.count   = RunNextLen;
        run_o.data[3] = cfg_i.next_ext;
        run_o.data[4] = frag_cnt_q[15:8];
        run_o.data[5] = frag_cnt_q[7:0];
        run_o.data[6] = pay;
      end
      default: begin
        run_o.count   = RunDataLen;
        run_o.data[0] = pay;
      end
    endcase
  end

  // Hold the input request until it is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q   <= in_byte_i;
      in_len_q    <= in_len_i;
      in_stream_q <= in_stream_i;
    end
  end

  // Advance message state on every pushed request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frag_cnt_q  <= '0;
      msg_left_q  <= '0;
      frag_left_q <= '0;
      pos_q       <= '0;
      stream_q    <= '0;
    end else if (push) begin
      frag_cnt_q  <= frag_cnt_d;
      msg_left_q  <= msg_left_d;
      frag_left_q <= frag_left_d;
      pos_q       <= pos_d;
      stream_q    <= stream_d;
    end
  end

endmodule

// ----- design/imf_serializer.sv -----
// ----------------------------------------------------------------------------
// imf_serializer
// Output byte shifter. Loads one run record and sends its bytes one per cycle
// while the sink is ready; takes the next record in the cycle its last byte is accepted.
// ----------------------------------------------------------------------------
module imf_serializer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           run_valid_i,
  output logic           run_ready_o,
  input  imf_pkg::run_t  run_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o,
  output logic           out_eof_o,
  output logic           out_eom_o
);
  import imf_pkg::*;

  logic [RunBytes-1:0][7:0] buf_q;
  logic [RunCntW-1:0]       left_q;
  logic                     eof_q;
  logic                     eom_q;
  logic                     fire;

  assign out_valid_o = (left_q != '0);
  assign out_last_o  = (left_q == RunCntW'(1));
  assign fire        = out_valid_o && out_ready_i;
  assign run_ready_o = !out_valid_o || (out_last_o && out_ready_i);
  assign out_byte_o  = buf_q[0];
  assign out_eof_o   = out_last_o && eof_q;
  assign out_eom_o   = out_last_o && eom_q;

  // Count remaining bytes of the current run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (run_valid_i) begin
      left_q <= run_i.count;
    end else if (fire) begin
      left_q <= left_q - RunCntW'(1);
    end
  end

  // Load a new run or shift out the sent byte
  always_ff @(posedge clk_i) begin
    if (run_valid_i) begin
      buf_q <= run_i.data;
      eof_q <= run_i.eof;
      eom_q <= run_i.eom;
    end else if (fire) begin
      buf_q <= buf_q >> 8;
    end
  end

endmodule

// ----- tb/tb_ipc_message_fragmenter_unit.sv -----
// ----------------------------------------------------------------------------
// tb_ipc_message_fragmenter_unit
// Self-checking bench for the message fragmenter. Messages are fed one payload
// byte per request, the expected frame bytes (headers, stream id overwrite,
// end-of-frame and end-of-message marks) are predicted per accepted request
// and compared in order against the frame byte stream, under random stalls on
// both sides and over several register settings.
// ----------------------------------------------------------------------------
module tb_ipc_message_fragmenter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import imf_pkg::*;

  localparam int unsigned IdleCycles = 16;
  localparam int unsigned StuckLimit = 1000;
  localparam int unsigned RandomTarget = 120;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       eom;
    logic       last;
  } frame_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [15:0] cfg_data = '0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [71:0] s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [7:0]  m_data;
  logic        m_last;
  logic [1:0]  m_user;

  ipc_message_fragmenter_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tlast (m_last),
    .m_axis_tuser (m_user)
  );

  always #6 clk_i = ~clk_i;

  // Register copies seen by the fragment predictor
  logic [15:0] max_frag = MaxFragReset;
  logic [7:0]  opcode = OpcodeReset;
  logic [7:0]  first_ext = FirstExtOpReset;
  logic [7:0]  next_ext = NextExtOpReset;

  // Fragmenter state mirror
  logic [15:0] frag_counter = '0;
  logic [31:0] msg_left = '0;
  logic [15:0] frag_left = '0;
  logic [3:0]  pay_pos = '0;
  logic [31:0] open_sid = '0;
  logic [15:0] frag_number = '0;

  frame_byte_t   frame_q[$];
  logic [71:0]   request_q[$];
  bit            quiet_src;
  bit            quiet_snk;
  int unsigned   n_pushed;
  int unsigned   n_accepted;
  int unsigned   n_bytes_out;
  int unsigned   n_msgs;
  int unsigned   n_cfg;
  int unsigned   n_errors;
  int unsigned   n_random;
  int unsigned   src_gap;
  int unsigned   snk_gap;
  int unsigned   stuck;

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_hdr(input logic [7:0] b);
    frame_q.push_back('{data: b, eof: 1'b0, eom: 1'b0, last: 1'b0});
  endfunction

  // Expected frame bytes for one accepted request
  function automatic void predict_fragments(input logic [71:0] req);
    logic [7:0]  pay;
    logic [31:0] len;
    logic [31:0] mx;
    logic [31:0] flen;
    pay = req[7:0];
    len = req[39:8];
    mx = (max_frag < MinFrag) ? 32'(MinFrag) : 32'(max_frag);
    if (msg_left == 0) begin
      // drop an opening request that carries no length
      if (len == 0) return;
      frag_counter = frag_counter + 16'd1;
      if (frag_counter == 0) frag_counter = 16'd1;
      frag_number = frag_counter;
      open_sid = req[71:40];
      pay_pos = '0;
      msg_left = len;
      if (len <= mx - 32'(FirstHdrLen)) begin
        flen = len + 32'(FirstHdrLen);
        frag_left = len[15:0];
      end else begin
        flen = mx;
        frag_left = 16'(mx - 32'(FirstHdrLen));
      end
      push_hdr(flen[15:8]);
      push_hdr(flen[7:0]);
      push_hdr(opcode);
      push_hdr(first_ext);
      push_hdr(len[31:24]);
      push_hdr(len[23:16]);
      push_hdr(len[15:8]);
      push_hdr(len[7:0]);
      push_hdr(frag_number[15:8]);
      push_hdr(frag_number[7:0]);
    end else if (frag_left == 0) begin
      if (msg_left <= mx - 32'(NextHdrLen)) begin
        flen = msg_left + 32'(NextHdrLen);
        frag_left = msg_left[15:0];
      end else begin
        flen = mx;
        frag_left = 16'(mx - 32'(NextHdrLen));
      end
      push_hdr(flen[15:8]);
      push_hdr(flen[7:0]);
      push_hdr(opcode);
      push_hdr(next_ext);
      push_hdr(frag_number[15:8]);
      push_hdr(frag_number[7:0]);
    end
    // overwrite payload bytes 4 to 7 with a nonzero stream id, big-endian
    if (pay_pos < 4'd8) begin
      if (pay_pos >= 4'd4 && open_sid != 0)
        pay = 8'(open_sid >> (8 * (7 - int'(pay_pos))));
      pay_pos = pay_pos + 4'd1;
    end
    frag_left = frag_left - 16'd1;
    msg_left = msg_left - 32'd1;
    frame_q.push_back('{data: pay, eof: frag_left == 0, eom: msg_left == 0, last: 1'b1});
  endfunction

  // Request driver: hand out queued requests with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        predict_fragments(s_data);
        n_accepted++;
      end
      if (!s_valid || s_ready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          s_data <= request_q.pop_front();
          s_valid <= 1'b1;
          src_gap = pick_gap(quiet_src);
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Frame byte monitor: stall at random and check each byte in order
  always @(posedge clk_i) begin
    frame_byte_t want;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        n_bytes_out++;
        if (frame_q.size() == 0) begin
          $error("frame_byte: no byte expected, got %02h", m_data);
          n_errors++;
        end else begin
          want = frame_q.pop_front();
          if (m_data !== want.data) begin
            $error("frame_byte: expected %02h, got %02h", want.data, m_data);
            n_errors++;
          end
          if (m_user[0] !== want.eof) begin
            $error("end_of_frame: expected %0b, got %0b", want.eof, m_user[0]);
            n_errors++;
          end
          if (m_user[1] !== want.eom) begin
            $error("end_of_message: expected %0b, got %0b", want.eom, m_user[1]);
            n_errors++;
          end
          if (m_last !== want.last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, m_last);
            n_errors++;
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
        snk_gap = pick_gap(quiet_snk);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        stuck = 0;
      end else begin
        stuck++;
        if (stuck >= StuckLimit) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      RegMaxFragSize: max_frag = val;
      RegOpcode:      opcode = val[7:0];
      RegFirstExtOp:  first_ext = val[7:0];
      RegNextExtOp:   next_ext = val[7:0];
      default: ;
    endcase
    n_cfg++;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Wait until every request is taken and every frame byte has come
  task automatic wait_idle();
    while (n_accepted != n_pushed || frame_q.size() != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  task automatic push_message(input logic [31:0] len, input logic [31:0] sid,
                              input logic [7:0] first_pay, input int unsigned nbytes);
    logic [71:0] r;
    for (int unsigned i = 0; i < nbytes; i++) begin
      r = {$urandom(), $urandom(), 8'($urandom())};
      if (i == 0) r = {sid, len, first_pay};
      request_q.push_back(r);
      n_pushed++;
    end
    if (len != 0) n_msgs++;
  endtask

  task automatic random_config();
    logic [15:0] mx;
    case ($urandom_range(0, 9))
      0: mx = 16'($urandom_range(0, 17));
      1: mx = 16'hFFFF;
      2: mx = MinFrag;
      default: mx = 16'($urandom_range(18, 48));
    endcase
    write_reg(RegMaxFragSize, mx);
    write_reg(RegOpcode, 16'($urandom()));
    write_reg(RegFirstExtOp, 16'($urandom()));
    write_reg(RegNextExtOp, 16'($urandom()));
  endtask

  initial begin
    int unsigned cap;
    int unsigned len;
    int unsigned n_phase_msgs;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: single byte, dropped empty opener, short messages with stream id
    push_message(32'd1, 32'd0, 8'h00, 1);
    push_message(32'd0, $urandom(), 8'hFF, 1);
    push_message(32'd5, 32'hA1B2C3D4, 8'hFF, 5);
    wait_idle();
    push_message(32'd8, 32'hFFFFFFFF, 8'h5A, 8);
    wait_idle();

    // Size below the minimum acts as the minimum: first fragment full, one tail
    write_reg(RegMaxFragSize, 16'd0);
    write_reg(RegOpcode, 16'h00FF);
    write_reg(RegFirstExtOp, 16'h0000);
    write_reg(RegNextExtOp, 16'hFFFF);
    push_message(32'd9, 32'd0, 8'h3C, 9);
    wait_idle();

    write_reg(RegMaxFragSize, 16'hFFFF);
    push_message(32'd3, 32'h00000001, 8'hC3, 3);
    wait_idle();

    // Random phases: new register setting, then a few messages
    while (n_random < RandomTarget) begin
      random_config();
      quiet_src = ($urandom_range(0, 3) == 0);
      quiet_snk = ($urandom_range(0, 3) == 0);
      cap = 32'(((max_frag < MinFrag) ? MinFrag : max_frag) - FirstHdrLen);
      n_phase_msgs = $urandom_range(2, 4);
      for (int unsigned m = 0; m < n_phase_msgs; m++) begin
        case ($urandom_range(0, 7))
          0: len = cap;
          1: len = cap + 1;
          2: len = $urandom_range(40, 70);
          default: len = $urandom_range(1, 30);
        endcase
        if (len > 70) len = $urandom_range(1, 30);
        if ($urandom_range(0, 9) == 0) push_message(32'd0, $urandom(), 8'($urandom()), 1);
        push_message(len, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom(),
                     8'($urandom()), len);
        n_random += len;
        if ($urandom_range(0, 3) == 0) wait_idle();
      end
      wait_idle();
    end

    // Largest length: open a message that never closes and stream part of it
    quiet_src = 1'b0;
    quiet_snk = 1'b0;
    write_reg(RegMaxFragSize, 16'($urandom_range(18, 30)));
    write_reg(RegOpcode, 16'($urandom()));
    write_reg(RegFirstExtOp, 16'($urandom()));
    write_reg(RegNextExtOp, 16'($urandom()));
    push_message(32'hFFFFFFFF, $urandom(), 8'($urandom()), 24);
    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d requests over %0d messages, %0d frame bytes checked,",
             n_accepted, n_msgs, n_bytes_out);
    $display("  %0d register writes across directed and random settings.", n_cfg);
    if (n_errors == 0 && frame_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
